### hw/rtl/rmv_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and controller/datapath command types for the running statistics engine.
package rmv_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = 40;
    localparam int SQ_W        = 54;
    localparam int PCOUNT_W    = 24;
    localparam int THRESH_W    = 24;
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 32;
    localparam int SE_W        = 16;
    localparam int TOTAL_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int OPCODE_W    = 2;

    // widest of the count-like quantities, for compares across them
    localparam int CMP_W = (COUNT_BITS > PCOUNT_W) ? COUNT_BITS : PCOUNT_W;

    // one quotient bit per cycle over the widest dividend
    localparam int DIV_STEPS  = SQ_W;
    localparam int SQRT_STEPS = SE_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // root remainder: 4 * (2 * root) + 3 must fit
    localparam int SQ_REM_W = SE_W + 3;

    localparam logic [THRESH_W-1:0] CONVERGE_RESET = THRESH_W'(10000);

    localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_MERGE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] RS_VALID    = 2'd0;
    localparam logic [STATUS_W-1:0] RS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] RS_NOT_CONV = 2'd2;

    typedef enum logic [1:0] {
        DIV_SEL_MEAN,
        DIV_SEL_SQ,
        DIV_SEL_SE
    } t_div_sel;

    typedef struct packed {
        logic     accept;     // apply the input beat (add or merge)
        logic     q_init;     // preset query results
        logic     div_load;
        t_div_sel div_sel;
        logic     div_step;
        logic     mean_take;
        logic     sq_take;    // square the saturated mean
        logic     var_take;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                count_zero;
        logic                count_lt2;
        logic                out_free;
    } t_dp_status;

endpackage

### hw/rtl/rmv_in_if.sv
`timescale 1ns / 1ps
// Input channel: opcode and operands with valid/ready.
interface rmv_in_if import rmv_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [OPCODE_W-1:0]           opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SUM_W-1:0]       partial_sum;
    logic [SQ_W-1:0]               partial_sum_sq;
    logic [PCOUNT_W-1:0]           partial_count;

    modport source (
        output valid, opcode, sample, partial_sum, partial_sum_sq, partial_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample, partial_sum, partial_sum_sq, partial_count,
        output ready
    );
endinterface

### hw/rtl/rmv_out_if.sv
`timescale 1ns / 1ps
// Result channel: query statistics with valid/ready.
interface rmv_out_if import rmv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean_value;
    logic [VAR_W-1:0]         variance_value;
    logic [SE_W-1:0]          standard_error;
    logic [TOTAL_W-1:0]       sample_total;
    logic                     is_converged;
    logic [STATUS_W-1:0]      result_status;
    logic                     overflowed;

    modport source (
        output valid, mean_value, variance_value, standard_error, sample_total,
               is_converged, result_status, overflowed,
        input  ready
    );
    modport sink (
        input  valid, mean_value, variance_value, standard_error, sample_total,
               is_converged, result_status, overflowed,
        output ready
    );
endinterface

### hw/rtl/rmv_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: input handshake and the query steps through divider and square root.
module rmv_ctrl import rmv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_Q_START,
        S_DIV_MEAN,
        S_MEAN_FIX,
        S_SQ_LOAD,
        S_DIV_SQ,
        S_VAR_FIX,
        S_SE_LOAD,
        S_DIV_SE,
        S_SQRT_LOAD,
        S_SQRT,
        S_RESULT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              accept;
    logic              div_last;
    logic              sqrt_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign div_last   = (r_cnt == STEP_W'(DIV_STEPS - 1));
    assign sqrt_last  = (r_cnt == STEP_W'(SQRT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_SEL_MEAN;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept && i_status.opcode == OP_QUERY) begin
                    n_state = S_Q_START;
                end
            end
            S_Q_START: begin
                o_cmd.q_init = 1'b1;
                if (i_status.count_zero) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = DIV_SEL_MEAN;
                    n_state        = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN, S_DIV_SQ, S_DIV_SE: begin
                o_cmd.div_step = 1'b1;
                if (div_last) begin
                    n_cnt = '0;
                    unique case (r_state)
                        S_DIV_MEAN: n_state = S_MEAN_FIX;
                        S_DIV_SQ:   n_state = S_VAR_FIX;
                        default:    n_state = S_SQRT_LOAD;
                    endcase
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_MEAN_FIX: begin
                o_cmd.mean_take = 1'b1;
                n_state = i_status.count_lt2 ? S_RESULT : S_SQ_LOAD;
            end
            S_SQ_LOAD: begin
                o_cmd.sq_take  = 1'b1;
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = DIV_SEL_SQ;
                n_state        = S_DIV_SQ;
            end
            S_VAR_FIX: begin
                o_cmd.var_take = 1'b1;
                n_state        = S_SE_LOAD;
            end
            S_SE_LOAD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_sel  = DIV_SEL_SE;
                n_state        = S_DIV_SE;
            end
            S_SQRT_LOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (sqrt_last) begin
                    n_cnt   = '0;
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_RESULT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_status.out_free)
        else $error("result loaded while output register still occupied");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("step counter not cleared at idle");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_status.opcode == OP_QUERY) |=> (r_state == S_Q_START))
        else $error("accepted query did not start");

endmodule

### hw/rtl/rmv_datapath.sv
`timescale 1ns / 1ps
// Accumulators, shared restoring divider, digit square root and output register.
module rmv_datapath import rmv_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_cfg_we,
    input  logic [THRESH_W-1:0]           i_cfg_wdata,
    input  logic [OPCODE_W-1:0]           i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SUM_W-1:0]       i_partial_sum,
    input  logic [SQ_W-1:0]               i_partial_sum_sq,
    input  logic [PCOUNT_W-1:0]           i_partial_count,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [MEAN_W-1:0]      o_mean_value,
    output logic [VAR_W-1:0]              o_variance_value,
    output logic [SE_W-1:0]               o_standard_error,
    output logic [TOTAL_W-1:0]            o_sample_total,
    output logic                          o_is_converged,
    output logic [STATUS_W-1:0]           o_result_status,
    output logic                          o_overflowed
);

    localparam logic [SQ_W-1:0] NEG_LIMIT = SQ_W'(1) << (MEAN_W - 1);
    localparam logic [SQ_W-1:0] POS_LIMIT = NEG_LIMIT - SQ_W'(1);
    localparam logic [SQ_W-1:0] VAR_LIMIT = SQ_W'({VAR_W{1'b1}});

    // architectural state
    logic [SUM_W-1:0]      r_sum;
    logic [SQ_W-1:0]       r_sum_sq;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_ovf;
    logic [THRESH_W-1:0]   r_thresh;

    // query working registers
    logic [COUNT_BITS-1:0] r_rem;
    logic [SQ_W-1:0]       r_dq;
    logic [MEAN_W:0]       r_mean_mag;
    logic [MEAN_W-1:0]     r_mean;
    logic [2*MEAN_W+1:0]   r_m2;
    logic [VAR_W-1:0]      r_var;
    logic [VAR_W-1:0]      r_sq_x;
    logic [SQ_REM_W-1:0]   r_sq_rem;
    logic [SE_W-1:0]       r_se;

    // output register
    logic                  r_out_valid;
    logic [MEAN_W-1:0]     r_o_mean;
    logic [VAR_W-1:0]      r_o_var;
    logic [SE_W-1:0]       r_o_se;
    logic [TOTAL_W-1:0]    r_o_total;
    logic                  r_o_conv;
    logic [STATUS_W-1:0]   r_o_status;
    logic                  r_o_ovf;

    logic signed [2*SAMPLE_BITS-1:0] sample_sq;
    logic [SUM_W-1:0]      sample_ext;
    logic                  count_full;
    logic                  merge_ovf;
    logic [CMP_W-1:0]      count_ext;
    logic                  sum_neg;
    logic [SUM_W-1:0]      sum_mag;
    logic [COUNT_BITS:0]   div_shift;
    logic [COUNT_BITS:0]   div_diff;
    logic                  div_ge;
    logic [SQ_W-1:0]       div_dividend;
    logic [MEAN_W:0]       mean_mag;
    logic [MEAN_W:0]       mean_neg;
    logic [SQ_W-1:0]       var_diff;
    logic [SQ_REM_W-1:0]   sq_shift;
    logic [SQ_REM_W-1:0]   sq_trial;
    logic                  sq_ge;
    logic                  conv;

    assign sample_sq  = (2*SAMPLE_BITS)'(i_sample) * (2*SAMPLE_BITS)'(i_sample);
    assign sample_ext = {{(SUM_W - SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
    assign count_full = &r_count;
    assign count_ext  = CMP_W'(r_count);
    // ~count is the headroom up to saturation
    assign merge_ovf  = CMP_W'(i_partial_count) > CMP_W'(~r_count);

    assign sum_neg = r_sum[SUM_W-1];
    assign sum_mag = sum_neg ? (SUM_W'(0) - r_sum) : r_sum;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_SEL_SQ: div_dividend = r_sum_sq;
            DIV_SEL_SE: div_dividend = SQ_W'(r_var);
            default:    div_dividend = SQ_W'(sum_mag);
        endcase
    end

    assign div_shift = {r_rem, r_dq[SQ_W-1]};
    assign div_diff  = div_shift - {1'b0, r_count};
    assign div_ge    = div_shift >= {1'b0, r_count};

    always_comb begin
        if (sum_neg) begin
            mean_mag = (r_dq > NEG_LIMIT) ? NEG_LIMIT[MEAN_W:0] : r_dq[MEAN_W:0];
        end else begin
            mean_mag = (r_dq > POS_LIMIT) ? POS_LIMIT[MEAN_W:0] : r_dq[MEAN_W:0];
        end
    end
    assign mean_neg = (MEAN_W + 1)'(0) - mean_mag;

    assign var_diff = (r_dq > SQ_W'(r_m2)) ? (r_dq - SQ_W'(r_m2)) : '0;

    assign sq_shift = {r_sq_rem[SQ_REM_W-3:0], r_sq_x[VAR_W-1 -: 2]};
    assign sq_trial = SQ_REM_W'({r_se, 2'b01});
    assign sq_ge    = sq_shift >= sq_trial;

    assign conv = count_ext >= CMP_W'(r_thresh);

    assign o_status.opcode     = i_opcode;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_lt2  = (r_count < COUNT_BITS'(2));
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // totals, flag, threshold and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sum_sq    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_thresh    <= CONVERGE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                case (i_opcode)
                    OP_ADD: begin
                        if (count_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_sum    <= r_sum + sample_ext;
                            r_sum_sq <= r_sum_sq + SQ_W'($unsigned(sample_sq));
                            r_count  <= r_count + COUNT_BITS'(1);
                        end
                    end
                    OP_MERGE: begin
                        if (merge_ovf) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_sum    <= r_sum + $unsigned(i_partial_sum);
                            r_sum_sq <= r_sum_sq + i_partial_sum_sq;
                            r_count  <= COUNT_BITS'(count_ext + CMP_W'(i_partial_count));
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_mean     <= '0;
            r_mean_mag <= '0;
            r_var      <= '1;
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_dq  <= div_dividend;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
            r_dq  <= {r_dq[SQ_W-2:0], div_ge};
        end
        if (i_cmd.mean_take) begin
            r_mean_mag <= mean_mag;
            r_mean     <= sum_neg ? mean_neg[MEAN_W-1:0] : mean_mag[MEAN_W-1:0];
        end
        if (i_cmd.sq_take) begin
            r_m2 <= (2*MEAN_W+2)'(r_mean_mag) * (2*MEAN_W+2)'(r_mean_mag);
        end
        if (i_cmd.var_take) begin
            r_var <= (var_diff > VAR_LIMIT) ? '1 : var_diff[VAR_W-1:0];
        end
        // root builds up in r_se; preset to all ones covers counts below two
        if (i_cmd.q_init) begin
            r_se <= '1;
        end else if (i_cmd.sqrt_load) begin
            r_sq_x   <= r_dq[VAR_W-1:0];
            r_sq_rem <= '0;
            r_se     <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sq_x   <= {r_sq_x[VAR_W-3:0], 2'b00};
            r_sq_rem <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
            r_se     <= {r_se[SE_W-2:0], sq_ge};
        end
        if (i_cmd.res_load) begin
            r_o_mean   <= r_mean;
            r_o_var    <= r_var;
            r_o_se     <= r_se;
            r_o_total  <= TOTAL_W'(count_ext);
            r_o_conv   <= conv;
            r_o_status <= (r_count == '0) ? RS_EMPTY : (conv ? RS_VALID : RS_NOT_CONV);
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mean_value     = $signed(r_o_mean);
    assign o_variance_value = r_o_var;
    assign o_standard_error = r_o_se;
    assign o_sample_total   = r_o_total;
    assign o_is_converged   = r_o_conv;
    assign o_result_status  = r_o_status;
    assign o_overflowed     = r_o_ovf;

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_ovf)) |-> r_ovf)
        else $error("overflow flag cleared outside reset");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("sample count decreased");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            (r_out_valid && $stable(r_o_var) && $stable(r_o_total)))
        else $error("result beat changed while stalled");

endmodule

### hw/rtl/running_mean_variance_stats.sv
`timescale 1ns / 1ps
// Top level of the running mean / variance statistics engine.
//
// Input channel i_in (valid/ready) carries an opcode and its operands. Add folds one
// Q8.8 sample into the sum, sum of squares and count; merge adds another engine's
// partial totals. Neither produces a result, so they stream at one
// beat per cycle while ready is high. Query produces one beat on o_out.
// A query runs up to three 54-step divisions on the one shared bit-serial divider
// and a 16-step square root (one division when the count is one, none when it is
// zero); ready stays low until the result is loaded into the free output register.
// If the receiver stalls, the result waits in the output register; the engine
// still takes add and merge beats, but a later query waits for the slot to clear.
// i_cfg_we / i_cfg_wdata write the converge threshold; write only when idle.
// Synchronous active-low reset clears the totals, count and overflow flag, sets the
// threshold to 10000 and empties the output register.
module running_mean_variance_stats import rmv_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rmv_in_if.sink              i_in,
    rmv_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [THRESH_W-1:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rmv_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_in.opcode),
        .i_sample         (i_in.sample),
        .i_partial_sum    (i_in.partial_sum),
        .i_partial_sum_sq (i_in.partial_sum_sq),
        .i_partial_count  (i_in.partial_count),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_mean_value     (o_out.mean_value),
        .o_variance_value (o_out.variance_value),
        .o_standard_error (o_out.standard_error),
        .o_sample_total   (o_out.sample_total),
        .o_is_converged   (o_out.is_converged),
        .o_result_status  (o_out.result_status),
        .o_overflowed     (o_out.overflowed)
    );

endmodule
